>>> rtl/shr_pkg.sv
// Shared types and constants for the sample history ring with window maximum.
package shr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 11;
  localparam int AGE_W  = 10;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CNT_W-1:0] SIZE_AT_RESET = 11'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the incoming item
    logic exec;      // perform the operation on the ring
    logic capture;   // capture the read result and start the scan
    logic scan;      // step the maximum scan
    logic load_out;  // move the result into the output register
    logic cfg_we;    // write the size register
  } shr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } shr_sts_t;

endpackage

>>> rtl/sample_history_ring_with_max_core.sv
// Top level of the sample history ring with window maximum.
//
// Usage: items enter on the in_ channel (opcode, sample_value, age_offset) and
// each item yields exactly one result item on the out_ channel (read_value,
// history_maximum, fill_count). An item is taken when in_valid is high and
// in_stall is low; a result is taken when out_valid is high and out_stall low.
// The ring size register is written over the cfg_ channel (cfg_valid and
// cfg_ready, data on cfg_data); a value different from the current one empties
// the history. It is written only while no item is in flight.
// Steps per item: an execute step, a capture step, a scan of the stored
// samples through the memory's single read port and a finish step that
// loads the result into the output register and raises out_valid.
// One item is processed at a time; the next is taken in the cycle after
// the result is loaded. A result waiting in the output register does not
// stop the next item from being taken; only the finish step waits while
// the receiver stalls.
// Reset (rst_n low at a clock edge) empties the history and sets the ring size
// to 64; the sample memory itself is not cleared and needs no clearing pass.
module sample_history_ring_with_max_core #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [shr_pkg::OP_W-1:0]    in_opcode,
  input  logic [shr_pkg::DATA_W-1:0]  in_sample_value,
  input  logic [shr_pkg::AGE_W-1:0]   in_age_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [shr_pkg::DATA_W-1:0]  out_read_value,
  output logic [shr_pkg::DATA_W-1:0]  out_history_maximum,
  output logic [shr_pkg::CNT_W-1:0]   out_fill_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [shr_pkg::CNT_W-1:0]   cfg_data
);
  import shr_pkg::*;

  shr_cmd_t cmd;
  shr_sts_t sts;

  // The controller only sequences; all ring state lives in the datapath.
  shr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  shr_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_sample_value    (in_sample_value),
    .in_age_offset      (in_age_offset),
    .cfg_data           (cfg_data),
    .out_read_value     (out_read_value),
    .out_history_maximum(out_history_maximum),
    .out_fill_count     (out_fill_count)
  );

endmodule

>>> rtl/shr_mem.sv
// Single-port-write, single-port-read sample memory with registered read data.
module shr_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [shr_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [shr_pkg::DATA_W-1:0] rdata
);
  import shr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/shr_ctrl.sv
// Controller state machine sequencing execute, capture, scan and output load.
module shr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  shr_pkg::shr_sts_t sts,
  output shr_pkg::shr_cmd_t cmd
);
  import shr_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    CAPT,
    SCAN,
    FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == IDLE) && in_valid;
    cmd.exec     = (state_r == EXEC);
    cmd.capture  = (state_r == CAPT);
    cmd.scan     = (state_r == SCAN);
    cmd.load_out = (state_r == FINISH) && (!out_valid_r || !out_stall);
    cmd.cfg_we   = (state_r == IDLE) && cfg_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_valid) begin
            state_r <= EXEC;
          end
        end
        EXEC: begin
          state_r <= CAPT;
        end
        CAPT: begin
          state_r <= SCAN;
        end
        SCAN: begin
          if (sts.scan_done) begin
            state_r <= FINISH;
          end
        end
        FINISH: begin
          if (cmd.load_out) begin
            state_r <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != IDLE);
  assign cfg_ready = (state_r == IDLE);
  assign out_valid = out_valid_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == IDLE && in_valid) |=> (state_r == EXEC))
    else $error("accepted item did not start execution");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == FINISH))
    else $error("result appeared without finishing an item");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FINISH && out_valid_r && out_stall) |=> (state_r == FINISH))
    else $error("result overwritten while the output was stalled");

endmodule

>>> rtl/shr_dp.sv
// Datapath: ring pointers, size register, read-by-age, maximum scan and output registers.
module shr_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  shr_pkg::shr_cmd_t           cmd,
  output shr_pkg::shr_sts_t           sts,
  input  logic [shr_pkg::OP_W-1:0]    in_opcode,
  input  logic [shr_pkg::DATA_W-1:0]  in_sample_value,
  input  logic [shr_pkg::AGE_W-1:0]   in_age_offset,
  input  logic [shr_pkg::CNT_W-1:0]   cfg_data,
  output logic [shr_pkg::DATA_W-1:0]  out_read_value,
  output logic [shr_pkg::DATA_W-1:0]  out_history_maximum,
  output logic [shr_pkg::CNT_W-1:0]   out_fill_count
);
  import shr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int XW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] sample_r;
  logic [AGE_W-1:0]  age_r;
  logic [CNT_W-1:0]  hs_r;
  logic [AW-1:0]     wi_r;
  logic [CNT_W-1:0]  vc_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic              pend_r;
  logic [DATA_W-1:0] max_r;
  logic [DATA_W-1:0] rv_r;
  logic [DATA_W-1:0] out_rv_r;
  logic [DATA_W-1:0] out_max_r;
  logic [CNT_W-1:0]  out_fill_r;

  logic [XW-1:0]     size;
  logic [XW-1:0]     wi_eff;
  logic [XW-1:0]     wi_inc;
  logic [XW-1:0]     pos_raw;
  logic [XW-1:0]     pos;
  logic              hit;
  logic              scan_issue;

  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Ring size in use: the register clamped to one through DEPTH.
  always_comb begin
    if (hs_r == '0) begin
      size = XW'(1);
    end else if (XW'(hs_r) > XW'(DEPTH)) begin
      size = XW'(DEPTH);
    end else begin
      size = XW'(hs_r);
    end
  end

  always_comb begin
    wi_eff  = (XW'(wi_r) >= size) ? '0 : XW'(wi_r);
    wi_inc  = wi_eff + XW'(1);
    pos_raw = size + XW'(wi_r) - XW'(age_r) - XW'(1);
    pos     = (pos_raw >= size) ? (pos_raw - size) : pos_raw;
    hit     = ({1'b0, age_r} < vc_r);
  end

  assign scan_issue = cmd.scan && (scan_idx_r < vc_r);
  assign mem_we     = cmd.exec && (op_r == OP_PUSH);
  assign mem_re     = (cmd.exec && (op_r == OP_READ)) || scan_issue;
  assign mem_raddr  = cmd.exec ? AW'(pos) : AW'(scan_idx_r);

  shr_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(AW'(wi_eff)),
    .wdata(sample_r),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r   <= SIZE_AT_RESET;
      wi_r   <= '0;
      vc_r   <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= scan_issue;
      if (cmd.cfg_we) begin
        hs_r <= cfg_data;
        if (cfg_data != hs_r) begin
          wi_r <= '0;
          vc_r <= '0;
        end
      end else if (cmd.exec) begin
        case (op_r)
          OP_PUSH: begin
            if (wi_inc > XW'(vc_r)) begin
              vc_r <= CNT_W'(wi_inc);
            end
            wi_r <= (wi_inc >= size) ? '0 : AW'(wi_inc);
          end
          OP_CLEAR: begin
            wi_r <= '0;
            vc_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_opcode;
      sample_r <= in_sample_value;
      age_r    <= in_age_offset;
    end
    if (cmd.capture) begin
      scan_idx_r <= '0;
      max_r      <= '0;
      if (op_r == OP_PUSH) begin
        rv_r <= sample_r;
      end else if (op_r == OP_READ && hit) begin
        rv_r <= mem_rdata;
      end else begin
        rv_r <= '0;
      end
    end else begin
      if (scan_issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      if (pend_r && (mem_rdata > max_r)) begin
        max_r <= mem_rdata;
      end
    end
    if (cmd.load_out) begin
      out_rv_r   <= rv_r;
      out_max_r  <= max_r;
      out_fill_r <= vc_r;
    end
  end

  assign sts.scan_done       = (scan_idx_r >= vc_r) && !pend_r;
  assign out_read_value      = out_rv_r;
  assign out_history_maximum = out_max_r;
  assign out_fill_count      = out_fill_r;

  a_fill_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(vc_r) <= size)
    else $error("fill count exceeds ring size");

  a_index_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(wi_r) < size)
    else $error("write index outside the ring");

endmodule

>>> sim/sample_history_ring_with_max_core_tb.sv
// Self-checking testbench for the sample history ring with window maximum.
`timescale 1ns / 1ps

module sample_history_ring_with_max_core_tb;
  import shr_pkg::*;

  localparam int RING_DEPTH = 1024;
  // Opcode 3 has no operation behind it; the block must leave the history alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One result item as the block should produce it.
  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [DATA_W-1:0] maximum;
    logic [CNT_W-1:0]  fill;
  } hist_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode = OP_PUSH;
  logic [DATA_W-1:0] in_sample_value = '0;
  logic [AGE_W-1:0]  in_age_offset = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_read_value;
  logic [DATA_W-1:0] out_history_maximum;
  logic [CNT_W-1:0]  out_fill_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  // Shadow copy of the ring as the block should hold it.
  logic [DATA_W-1:0] shadow_ring [RING_DEPTH];
  int unsigned       shadow_wr_ptr = 0;
  int unsigned       shadow_fill = 0;
  logic [CNT_W-1:0]  shadow_size = SIZE_AT_RESET;

  hist_result_t      expected_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       results_checked = 0;
  int unsigned       size_writes = 0;
  // When low, neither the sender nor the receiver inserts idle cycles.
  bit                idle_on = 1'b1;

  sample_history_ring_with_max_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_sample_value     (in_sample_value),
    .in_age_offset       (in_age_offset),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_value      (out_read_value),
    .out_history_maximum (out_history_maximum),
    .out_fill_count      (out_fill_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // The ring size in effect: the register clamped into 1..RING_DEPTH, so a
  // register value of 0 behaves as a ring of one entry.
  function automatic int unsigned active_span();
    int unsigned s;
    s = shadow_size;
    if (s < 1) s = 1;
    if (s > RING_DEPTH) s = RING_DEPTH;
    return s;
  endfunction

  // Applies one accepted item to the shadow ring and queues the result it
  // must produce. Valid samples always sit at indices 0 .. fill-1, since the
  // ring is filled from index 0 after every clear.
  task automatic compute_history_result(input logic [OP_W-1:0] op,
                                        input logic [DATA_W-1:0] sample,
                                        input logic [AGE_W-1:0] age);
    int unsigned  span;
    int unsigned  wp;
    int unsigned  pos;
    hist_result_t r;
    span = active_span();
    r = '0;
    case (op)
      OP_PUSH: begin
        wp = shadow_wr_ptr;
        if (wp >= span) wp = 0;
        shadow_ring[wp] = sample;
        wp++;
        if (wp > shadow_fill) shadow_fill = wp;
        if (wp >= span) wp = 0;
        shadow_wr_ptr = wp;
        r.read_value = sample;
      end
      OP_READ: begin
        // An age at or beyond the fill count reads as zero.
        if (age < shadow_fill) begin
          pos = span + shadow_wr_ptr - age - 1;
          if (pos >= span) pos -= span;
          r.read_value = shadow_ring[pos];
        end
      end
      OP_CLEAR: begin
        shadow_wr_ptr = 0;
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    for (int unsigned i = 0; i < shadow_fill; i++) begin
      if (shadow_ring[i] > r.maximum) r.maximum = shadow_ring[i];
    end
    r.fill = shadow_fill[CNT_W-1:0];
    expected_results.push_back(r);
  endtask

  // Presents one item and waits until the block takes it. Called right after
  // a rising edge; in_valid stays high so that back-to-back items need no
  // second assignment in the same step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] sample,
                           input logic [AGE_W-1:0] age);
    if (idle_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_sample_value <= sample;
    in_age_offset   <= age;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_history_result(op, sample, age);
    items_sent++;
  endtask

  // Waits until every queued result has come back, so the block is idle.
  task automatic drain_history();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the size register. A value that differs from the current one
  // empties the history; an equal value leaves it untouched.
  task automatic write_ring_size(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (value != shadow_size) begin
      shadow_wr_ptr = 0;
      shadow_fill = 0;
    end
    shadow_size = value;
    size_writes++;
    @(posedge clk);
  endtask

  // One random item. Half the samples are full-range; small ones and the two
  // extremes make the maximum move when old entries are overwritten. Most
  // reads land inside the valid history.
  task automatic send_random_item(input int unsigned clear_pct);
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] s;
    logic [AGE_W-1:0]  a;
    pick = $urandom_range(99);
    if (pick < 58 - clear_pct) op = OP_PUSH;
    else if (pick < 94 - clear_pct) op = OP_READ;
    else if (pick < 94) op = OP_CLEAR;
    else op = OP_UNUSED;
    case ($urandom_range(7))
      0: s = '0;
      1: s = '1;
      2, 3: s = $urandom_range(255);
      default: s = $urandom;
    endcase
    case ($urandom_range(9))
      7: a = (shadow_fill > 1023) ? 10'd1023 : shadow_fill[AGE_W-1:0];
      8: a = AGE_W'($urandom_range(1023));
      9: a = 10'd1023;
      default: a = (shadow_fill > 0) ? AGE_W'($urandom_range(shadow_fill - 1)) : 10'd0;
    endcase
    send_item(op, s, a);
  endtask

  // A random phase at one ring size. Now and then the same size is written
  // a second time, which must keep the history.
  task automatic run_random_phase(input logic [CNT_W-1:0] size, input int unsigned n_items,
                                  input int unsigned clear_pct);
    drain_history();
    write_ring_size(size);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == n_items / 2 && $urandom_range(1) == 1) begin
        drain_history();
        write_ring_size(size);
      end
      send_random_item(clear_pct);
    end
  endtask

  // Right after reset the history is empty: reads give zero, the unused
  // opcode and a clear change nothing.
  task automatic test_empty_history();
    send_item(OP_READ, '1, 10'd0);
    send_item(OP_UNUSED, '1, 10'd1023);
    send_item(OP_CLEAR, 32'h1234_5678, 10'd5);
    send_item(OP_READ, '0, 10'd1023);
  endtask

  // Pushes and reads at the reset size of 64, including reads that reach
  // beyond the fill count and a size write of the value already held.
  task automatic test_push_and_read();
    send_item(OP_PUSH, '0, 10'd0);
    send_item(OP_PUSH, '1, 10'd1023);
    send_item(OP_PUSH, 32'h0000_0005, 10'd0);
    send_item(OP_READ, '0, 10'd0);
    send_item(OP_READ, '0, 10'd1);
    send_item(OP_READ, '0, 10'd2);
    send_item(OP_READ, '0, 10'd3);
    send_item(OP_UNUSED, 32'hA5A5_A5A5, 10'd1);
    drain_history();
    write_ring_size(SIZE_AT_RESET);
    send_item(OP_READ, '0, 10'd2);
    send_item(OP_CLEAR, '0, 10'd0);
    send_item(OP_READ, '0, 10'd0);
  endtask

  // Tiny rings: one entry, a register value of zero acting as one entry,
  // and a three-entry ring that wraps.
  task automatic test_small_rings();
    drain_history();
    write_ring_size(11'd1);
    send_item(OP_PUSH, 32'hDEAD_BEEF, 10'd0);
    send_item(OP_PUSH, 32'h0000_0010, 10'd0);
    send_item(OP_READ, '0, 10'd1);
    drain_history();
    write_ring_size(11'd0);
    send_item(OP_PUSH, 32'h8000_0000, 10'd0);
    send_item(OP_READ, '0, 10'd0);
    drain_history();
    write_ring_size(11'd3);
    for (int unsigned i = 0; i < 4; i++) send_item(OP_PUSH, 32'h100 - i, 10'd0);
    send_item(OP_READ, '0, 10'd2);
  endtask

  // The largest sizes: the full register value clamps to the memory depth,
  // and the full depth runs with few clears so the history grows long.
  task automatic test_size_extremes();
    run_random_phase(11'd2047, 40, 2);
    run_random_phase(11'd1024, 150, 1);
  endtask

  // Small random rings, so that wrapping happens often, plus one near the
  // full depth.
  task automatic test_random_rings();
    for (int unsigned p = 0; p < 7; p++) begin
      if (p == 3) run_random_phase(11'd1023, 45, 4);
      else run_random_phase(CNT_W'($urandom_range(1, 40)), 45, 6);
    end
  endtask

  // A long stretch in which neither side ever idles.
  task automatic test_steady_no_idle();
    drain_history();
    idle_on = 1'b0;
    run_random_phase(CNT_W'($urandom_range(2, 20)), 60, 5);
    drain_history();
    idle_on = 1'b1;
  endtask

  // Result checking. Everything is sampled at the rising edge, before the
  // block's own updates of that edge land, and out_stall for the next cycle
  // is chosen afterwards with one nonblocking assignment.
  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result item arrived with no item pending");
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_read_value !== want.read_value)
          flag_mismatch($sformatf("read_value %h, expected %h",
                                  out_read_value, want.read_value));
        if (out_history_maximum !== want.maximum)
          flag_mismatch($sformatf("history_maximum %h, expected %h",
                                  out_history_maximum, want.maximum));
        if (out_fill_count !== want.fill)
          flag_mismatch($sformatf("fill_count %0d, expected %0d",
                                  out_fill_count, want.fill));
      end
    end
    out_stall <= idle_on && ($urandom_range(99) < 16);
  end

  // Main sequence: one reset, the directed tests, then the random ones.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_history();
    test_push_and_read();
    test_small_rings();
    test_size_extremes();
    test_random_rings();
    test_steady_no_idle();
    drain_history();
    // Leave room for a late spurious result: one full scan of the history.
    repeat (shadow_fill + 8) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d items through %0d size writes; %0d results checked.",
             items_sent, size_writes, results_checked);
    $display("Covered push, read by age, clear, unused opcode and ring sizes 0 to 2047.");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("Timeout: the run did not complete.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
rtl/shr_pkg.sv
rtl/shr_mem.sv
rtl/shr_ctrl.sv
rtl/shr_dp.sv
rtl/sample_history_ring_with_max_core.sv
sim/sample_history_ring_with_max_core_tb.sv
